// ===== src/olt_pkg.sv =====
// Shared types and codes for the ordered list table.
// Holds command, status and cell operation codes and the probe struct.
// No dependencies.
`default_nettype none

package olt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int POS_W     = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    // operation carried by a probe down the cell row
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef struct packed {
        logic                     valid;
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic                     found;
        logic [POS_W-1:0]         found_pos;
        logic signed [DATA_W-1:0] data;
    } probe_t;

endpackage : olt_pkg

`default_nettype wire

// ===== src/olt_req_if.sv =====
// Command channel of the ordered list table: valid/ready plus payload.
// Depends on olt_pkg.
`default_nettype none

interface olt_req_if
    import olt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface : olt_req_if

`default_nettype wire

// ===== src/olt_rsp_if.sv =====
// Result channel of the ordered list table: valid/ready plus payload.
// Depends on olt_pkg.
`default_nettype none

interface olt_rsp_if
    import olt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [3:0]               found_position;
    logic [4:0]               entry_count;
    logic                     is_empty;

    modport source (output valid, status, data, found_position, entry_count, is_empty,
                    input ready);
    modport sink   (input valid, status, data, found_position, entry_count, is_empty,
                    output ready);
endinterface : olt_rsp_if

`default_nettype wire

// ===== src/olt_cell.sv =====
// One cell of the list row: stores one entry and acts on the passing probe.
// Depends on olt_pkg.
`default_nettype none

module olt_cell
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire probe_t           probe_in,
    input  wire logic [CNT_W-1:0] count,
    output probe_t                probe_out
);

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    probe_t                   probe_reg, probe_next;
    logic                     hit;
    logic                     live;

    assign hit  = probe_in.valid && (probe_in.pos == POS_W'(INDEX));
    assign live = 17'(INDEX) < 17'(count);

    // act on the probe and pass it on
    always_comb
    begin
        probe_next = probe_in;
        entry_next = entry_reg;
        unique case (probe_in.op)
            OP_NONE:
            begin
            end
            OP_WRITE:
            begin
                if (hit)
                begin
                    entry_next = probe_in.value;
                end
            end
            OP_READ:
            begin
                if (hit)
                begin
                    probe_next.data = entry_reg;
                end
            end
            OP_SEARCH:
            begin
                if (probe_in.valid && !probe_in.found && live &&
                    entry_reg == probe_in.value)
                begin
                    probe_next.found     = 1'b1;
                    probe_next.found_pos = POS_W'(INDEX);
                end
            end
        endcase
    end

    // entry storage, no reset: read only after written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule : olt_cell

`default_nettype wire

// ===== src/ordered_list_table_core.sv =====
// Ordered list table: one command beat in, one result beat out.
// An accepted command becomes the head probe, which walks the DEPTH cells one per cycle;
// the result goes to the pending registers, then the output register. No new command is taken
// before that; a finished result may wait in the output register while the next command runs.
// Reset empties the list (count zero); stored entries are undefined until written.
// Depends on olt_pkg, olt_req_if, olt_rsp_if and olt_cell.
`default_nettype none

module ordered_list_table_core
    import olt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    olt_req_if.sink   req,
    olt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    probe_t                   head_reg, head_next;
    status_t                  pre_reg, pre_next;
    status_t                  pend_status_reg, pend_status_next;
    logic signed [DATA_W-1:0] pend_data_reg, pend_data_next;
    logic [POS_W-1:0]         pend_pos_reg, pend_pos_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic [POS_W-1:0]         out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    probe_t                   chain [DEPTH+1];
    logic                     accept;
    logic                     out_free;
    logic                     full;
    logic                     in_range;
    logic [16:0]              cnt_ext;

    // cell row
    assign chain[0] = head_reg;
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        olt_cell #(
            .DEPTH (DEPTH),
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (chain[i]),
            .count     (count_reg),
            .probe_out (chain[i+1])
        );
    end

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign full      = count_reg >= CNT_W'(DEPTH);
    assign in_range  = {1'b0, req.position} < 17'(count_reg);

    // command decode, probe launch, result capture
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = '0;
        pre_next         = pre_reg;
        pend_status_next = pend_status_reg;
        pend_data_next   = pend_data_reg;
        pend_pos_next    = pend_pos_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_pos_next     = out_pos_reg;
        out_count_next   = out_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    head_next.valid = 1'b1;
                    head_next.value = req.value;
                    head_next.pos   = req.position;
                    head_next.op    = OP_NONE;
                    pre_next        = STAT_OK;
                    priority if (cmd_t'(req.command) == CMD_APPEND)
                    begin
                        if (full)
                        begin
                            pre_next = STAT_FULL;
                        end
                        else
                        begin
                            head_next.op  = OP_WRITE;
                            head_next.pos = POS_W'(count_reg);
                            count_next    = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        pre_next = STAT_EMPTY;
                    end
                    else if (cmd_t'(req.command) == CMD_SEARCH)
                    begin
                        head_next.op = OP_SEARCH;
                        pre_next     = STAT_NOTFOUND;
                    end
                    else if (!in_range)
                    begin
                        pre_next = STAT_RANGE;
                    end
                    else if (cmd_t'(req.command) == CMD_READ)
                    begin
                        head_next.op = OP_READ;
                    end
                    else
                    begin
                        head_next.op = OP_WRITE;
                    end
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (chain[DEPTH].valid)
                begin
                    pend_status_next = (chain[DEPTH].found) ? STAT_OK : pre_reg;
                    pend_data_next   = chain[DEPTH].data;
                    pend_pos_next    = chain[DEPTH].found_pos;
                    state_next       = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_data_next   = pend_data_reg;
                    out_pos_next    = pend_pos_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pre_reg         <= pre_next;
        pend_status_reg <= pend_status_next;
        pend_data_reg   <= pend_data_next;
        pend_pos_reg    <= pend_pos_next;
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
        out_pos_reg     <= out_pos_next;
        out_count_reg   <= out_count_next;
    end

    // result beat
    assign cnt_ext            = 17'(out_count_reg);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.data           = out_data_reg;
    assign rsp.found_position = out_pos_reg[3:0];
    assign rsp.entry_count    = cnt_ext[4:0];
    assign rsp.is_empty       = (out_count_reg == '0);

endmodule : ordered_list_table_core

`default_nettype wire
